>>> src/stce_pkg.sv
// Shared types and constants for the staged table commit engine.
// No dependencies; used by the top level.
package stce_pkg;

    localparam int DEF_ENTRIES = 64;
    localparam int DEF_PORTS   = 4;

    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 7 * BYTE_W;
    localparam int PORT_W      = 3;
    localparam int IDX_OUT_W   = 6;
    localparam int IN_DATA_W   = 11 * BYTE_W;
    localparam int OUT_DATA_W  = 80;
    localparam int OUT_PAD_W   = OUT_DATA_W - ENTRY_W - IDX_OUT_W - BYTE_W - PORT_W;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_SET    = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_IDLE  = 2'd0,
        STAT_OK    = 2'd1,
        STAT_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CODE_IDLE    = 3'd0,
        CODE_OK      = 3'd1,
        CODE_ERROR   = 3'd2,
        CODE_ENTRY   = 3'd3,
        CODE_REFUSED = 3'd4
    } code_t;

endpackage

>>> src/stce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module stce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/staged_table_commit_engine_top.sv
// Staged table commit engine: the result of a begin, set, cancel, refused-size or zero-count commit
// is registered and appears in the cycle after acceptance; one such command per cycle while the
// output drains. A commit walks the arrived bitmap with a shared index counter and compare, one
// entry per cycle, then emits each entry by a RAM fetch, a load and a wait for the sink to take it.
// Reset (rst_n, asynchronous, active low) clears status, port, scope, arrived bitmap and
// handshake state at once; the entry RAM is not cleared. Depends on stce_pkg and stce_ram.
module staged_table_commit_engine_top #(
    parameter int ENTRIES = stce_pkg::DEF_ENTRIES,
    parameter int PORTS   = stce_pkg::DEF_PORTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input transactions
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0 up: target_port, entry_slot, source_button, dest_button, dest_device,
    // percent_max, percent_threshold, percent_deadzone, turbo_mode, commit_count, commit_scope
    input  logic [stce_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: command
    input  logic [1:0]                      s_tuser,
    // Result transactions
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0 up: port_out, scope_out, index_out, src_out, dst_out, dev_out,
    // max_out, thresh_out, dead_out, turbo_out, zero pad
    output logic [stce_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: code
    output logic [2:0]                      m_tuser,
    // tlast: last
    output logic                            m_tlast
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int BW    = stce_pkg::BYTE_W;

    // One-hot sequencer: idle, bitmap scan, RAM read, load result, wait for the sink
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_LOAD  = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    stce_pkg::status_t            status_reg, status_next;
    logic [stce_pkg::PORT_W-1:0]  port_reg, port_next;
    logic [BW-1:0]                scope_reg, scope_next;
    logic [ENTRIES-1:0]           arrived_reg, arrived_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    // Output register: parts the sink from the sequencer
    logic                         out_valid_reg, out_valid_next;
    stce_pkg::code_t              out_code_reg, out_code_next;
    logic [stce_pkg::PORT_W-1:0]  out_port_reg, out_port_next;
    logic [BW-1:0]                out_scope_reg, out_scope_next;
    logic [stce_pkg::IDX_OUT_W-1:0] out_index_reg, out_index_next;
    logic [stce_pkg::ENTRY_W-1:0] out_entry_reg, out_entry_next;
    logic                         out_last_reg, out_last_next;

    logic                         accept;
    logic                         load_status;
    stce_pkg::cmd_t               cmd;
    logic [BW-1:0]                in_port;
    logic [BW-1:0]                in_slot;
    logic [BW-1:0]                in_count;
    logic [BW-1:0]                in_scope;
    logic [stce_pkg::ENTRY_W-1:0] in_entry;
    logic [IDX_W-1:0]             slot_idx;
    logic [IDX_W-1:0]             cnt_idx;
    logic [CNT_W-1:0]             cnt_inc;
    logic                         cnt_at_end;
    logic                         ram_we;
    logic [stce_pkg::ENTRY_W-1:0] ram_q;

    // Unpack the input transaction
    assign cmd      = stce_pkg::cmd_t'(s_tuser);
    assign in_port  = s_tdata[BW-1:0];
    assign in_slot  = s_tdata[2*BW-1:BW];
    assign in_entry = s_tdata[9*BW-1:2*BW];
    assign in_count = s_tdata[10*BW-1:9*BW];
    assign in_scope = s_tdata[11*BW-1:10*BW];
    assign slot_idx = in_slot[IDX_W-1:0];

    // Shared index unit: one counter and one end compare serve both scan and emit
    assign cnt_idx    = cnt_reg[IDX_W-1:0];
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign cnt_at_end = (cnt_inc == count_reg);

    // Take a command only when idle and the output register is free or draining
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    stce_ram #(
        .WIDTH (stce_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (in_entry),
        .raddr (cnt_idx),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        port_next      = port_reg;
        scope_next     = scope_reg;
        arrived_next   = arrived_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        out_code_next  = out_code_reg;
        out_port_next  = out_port_reg;
        out_scope_next = out_scope_reg;
        out_index_next = out_index_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        load_status    = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        stce_pkg::CMD_BEGIN:
                        begin
                            if (in_port < BW'(PORTS))
                            begin
                                port_next    = in_port[stce_pkg::PORT_W-1:0];
                                arrived_next = '0;
                                status_next  = stce_pkg::STAT_IDLE;
                            end
                            load_status = 1'b1;
                        end
                        stce_pkg::CMD_SET:
                        begin
                            if (in_slot < BW'(ENTRIES))
                            begin
                                ram_we                 = 1'b1;
                                arrived_next[slot_idx] = 1'b1;
                            end
                            load_status = 1'b1;
                        end
                        stce_pkg::CMD_COMMIT:
                        begin
                            if ({1'b0, in_count} <= (BW + 1)'(ENTRIES))
                            begin
                                scope_next = in_scope;
                                count_next = CNT_W'(in_count);
                                cnt_next   = '0;
                                if (in_count == '0)
                                begin
                                    status_next = stce_pkg::STAT_OK;
                                    load_status = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                            else
                            begin
                                load_status = 1'b1;
                            end
                        end
                        stce_pkg::CMD_CANCEL:
                        begin
                            status_next = stce_pkg::STAT_IDLE;
                            load_status = 1'b1;
                        end
                        default:
                        begin
                            load_status = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Check one arrived bit per cycle; stop at the first hole
                if (!arrived_reg[cnt_idx])
                begin
                    status_next    = stce_pkg::STAT_ERROR;
                    out_valid_next = 1'b1;
                    out_code_next  = stce_pkg::CODE_REFUSED;
                    out_port_next  = port_reg;
                    out_scope_next = scope_reg;
                    out_index_next = stce_pkg::IDX_OUT_W'(cnt_reg);
                    out_entry_next = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (cnt_at_end)
                begin
                    status_next = stce_pkg::STAT_OK;
                    cnt_next    = '0;
                    state_next  = S_FETCH;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_FETCH:
            begin
                // RAM read address follows the counter; data lands next cycle
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_valid_next = 1'b1;
                out_code_next  = stce_pkg::CODE_ENTRY;
                out_port_next  = port_reg;
                out_scope_next = scope_reg;
                out_index_next = stce_pkg::IDX_OUT_W'(cnt_reg);
                out_entry_next = ram_q;
                out_last_next  = cnt_at_end;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                // Hold until the sink takes the entry, then advance or finish
                if (m_tready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Status result reflects the state after this command's update
        if (load_status)
        begin
            out_valid_next = 1'b1;
            out_code_next  = stce_pkg::code_t'({1'b0, status_next});
            out_port_next  = port_next;
            out_scope_next = scope_next;
            out_index_next = '0;
            out_entry_next = '0;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= stce_pkg::STAT_IDLE;
            port_reg      <= '0;
            scope_reg     <= '0;
            arrived_reg   <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            port_reg      <= port_next;
            scope_reg     <= scope_next;
            arrived_reg   <= arrived_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        out_port_reg  <= out_port_next;
        out_scope_reg <= out_scope_next;
        out_index_reg <= out_index_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{stce_pkg::OUT_PAD_W{1'b0}}, out_entry_reg, out_index_reg,
                       out_scope_reg, out_port_reg};

    // Sequencer stays one-hot through reset and operation
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // The output register is empty whenever the bitmap scan runs
    a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !out_valid_reg)
        else $error("scan running while a result is pending");

    // Only entries that have arrived are ever loaded for emission
    a_load_arrived: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> arrived_reg[cnt_idx])
        else $error("emitting an entry that never arrived");

    // A refusal leaves the status at error
    a_refuse_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_code_reg == stce_pkg::CODE_REFUSED)
        |-> status_reg == stce_pkg::STAT_ERROR)
        else $error("refusal without error status");

    // Only committed entries may be non-final results
    a_nonlast_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> out_code_reg == stce_pkg::CODE_ENTRY)
        else $error("non-final result that is not an entry");

endmodule
